### rtl/set_assoc_writeback_cache_lookup_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the set associative write-back cache lookup
// Shared property wrappers, clocked on clk_i and quiet while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_WRITEBACK_CACHE_LOOKUP_DEFINES_SVH
`define SET_ASSOC_WRITEBACK_CACHE_LOOKUP_DEFINES_SVH

// Same-cycle implication.
`define SAWBC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SAWBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sawbc_pkg.sv
// ----------------------------------------------------------------------------
// Set associative write-back cache lookup package
// Beat types, per-line metadata and register map shared by the lookup block.
// ----------------------------------------------------------------------------
package sawbc_pkg;

  localparam int unsigned TAG_W      = 32;
  localparam int unsigned RANK_W     = 3;
  localparam int unsigned SET_RAW_W  = 7;   // widest set index before wrap
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_INDEX_BITS  = 2'd0;
  localparam logic [1:0] REG_OFFSET_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS        = 2'd2;

  typedef struct packed {
    logic        cmd;
    logic [31:0] address;
  } cache_req_t;

  typedef struct packed {
    logic       hit;
    logic       writeback_needed;
    logic [2:0] way_used;
  } cache_rsp_t;

  typedef struct packed {
    logic              valid;
    logic              dirty;
    logic [RANK_W-1:0] rank;
  } line_meta_t;

endpackage

### rtl/set_assoc_writeback_cache_lookup.sv
// ----------------------------------------------------------------------------
// Set associative write-back cache lookup with LRU replacement
// Looks up one read or write per beat, reports hit, write-back and way used.
// ----------------------------------------------------------------------------
// One access goes through a single tag comparator that walks the ways of the
// selected set, one way per cycle, out of a one-port tag memory. The walk ends
// at the first hit, or on a miss after the last way of the clamped
// associativity; no new access is taken until its result is registered.
// The set's valid, dirty and age bits come out of a row memory in the
// accepting cycle and go back in one write once the way is chosen.
// After reset a clearing pass zeroes that row memory row by row; no access
// is taken until it ends, register writes are taken throughout.
// A result waits in an output register, so the next access may be accepted
// while it is stalled; that access then holds in its update state until the
// register is free.

`include "set_assoc_writeback_cache_lookup_defines.svh"

module set_assoc_writeback_cache_lookup
  import sawbc_pkg::*;
#(
  parameter int unsigned MAX_WAYS = 8,
  parameter int unsigned MAX_SETS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // access channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  cache_req_t            in_data_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output cache_rsp_t            out_data_o,
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned WAY_CNT_W = $clog2(MAX_WAYS + 1);
  localparam int unsigned SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned TAG_DEPTH = MAX_SETS << WAY_W;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_UPDATE = 2'd3;

  // registers
  logic [2:0] index_bits_q;
  logic [3:0] offset_bits_q;
  logic [3:0] ways_q;

  logic [1:0] state_q, state_d;
  logic [SET_W-1:0] clr_idx_q;

  // memories
  logic [TAG_W-1:0]          tag_mem [TAG_DEPTH];
  line_meta_t [MAX_WAYS-1:0] meta_mem [MAX_SETS];
  logic [TAG_W-1:0]          tag_rd_q;
  line_meta_t [MAX_WAYS-1:0] meta_rd_q;

  // item context
  logic [SET_W-1:0]  set_q;
  logic [TAG_W-1:0]  tag_q;
  logic              is_write_q;
  logic [WAY_W-1:0]  cmp_q;
  logic [WAY_W-1:0]  sel_way_q;
  logic              hit_q;
  logic              fill_free_q;
  logic              free_found_q;
  logic [WAY_W-1:0]  free_way_q;
  logic [WAY_W-1:0]  vic_way_q;
  logic [RANK_W-1:0] vic_rank_q;

  logic       out_valid_q;
  cache_rsp_t out_data_q;

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------
  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_bits_q  <= 3'd4;
      offset_bits_q <= 4'd3;
      ways_q        <= 4'd8;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_INDEX_BITS:  index_bits_q  <= pwdata[2:0];
        REG_OFFSET_BITS: offset_bits_q <= pwdata[3:0];
        REG_WAYS:        ways_q        <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_INDEX_BITS:  prdata = {29'd0, index_bits_q};
      REG_OFFSET_BITS: prdata = {28'd0, offset_bits_q};
      REG_WAYS:        prdata = {28'd0, ways_q};
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Address split and set wrap
  // ---------------------------------------------------------------------------
  logic [31:0]          addr_shr;
  logic [SET_RAW_W-1:0] set_raw;
  logic [31:0]          set_rem;
  logic [4:0]           tag_shift;
  logic [SET_W-1:0]     set_d;
  logic [TAG_W-1:0]     tag_d;

  assign addr_shr  = in_data_i.address >> offset_bits_q;
  assign set_raw   = addr_shr[SET_RAW_W-1:0] &
                     ((SET_RAW_W'(1) << index_bits_q) - SET_RAW_W'(1));
  assign tag_shift = {1'b0, offset_bits_q} + {2'b00, index_bits_q};
  assign tag_d     = in_data_i.address >> tag_shift;

  // restoring reduction modulo MAX_SETS, one quotient bit per step
  always_comb begin
    set_rem = {{(32 - SET_RAW_W){1'b0}}, set_raw};
    for (int j = SET_RAW_W - 1; j >= 0; j--) begin
      if (set_rem >= (32'(MAX_SETS) << j)) begin
        set_rem = set_rem - (32'(MAX_SETS) << j);
      end
    end
  end
  assign set_d = set_rem[SET_W-1:0];

  // ---------------------------------------------------------------------------
  // Way walk
  // ---------------------------------------------------------------------------
  logic [4:0]           ways_ext;
  logic [WAY_CNT_W-1:0] ways_eff;
  logic                 accept;
  logic                 scan_last;
  logic                 scan_hit;
  line_meta_t           cur_meta;
  logic                 free_found_s;
  logic [WAY_W-1:0]     free_way_s;
  logic                 vic_take;
  logic [WAY_W-1:0]     vic_way_s;
  logic [RANK_W-1:0]    vic_rank_s;
  logic                 upd_go;

  assign ways_ext = {1'b0, ways_q};
  always_comb begin
    if (ways_ext == 5'd0) begin
      ways_eff = WAY_CNT_W'(1);
    end else if (ways_ext > 5'(MAX_WAYS)) begin
      ways_eff = WAY_CNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WAY_CNT_W'(ways_ext);
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  assign cur_meta     = meta_rd_q[cmp_q];
  assign scan_hit     = cur_meta.valid && (tag_rd_q == tag_q);
  assign scan_last    = (WAY_CNT_W'(cmp_q) == ways_eff - WAY_CNT_W'(1));
  assign free_found_s = free_found_q || !cur_meta.valid;
  assign free_way_s   = free_found_q ? free_way_q : cmp_q;
  assign vic_take     = (cmp_q == '0) || (cur_meta.rank > vic_rank_q);
  assign vic_way_s    = vic_take ? cmp_q : vic_way_q;
  assign vic_rank_s   = vic_take ? cur_meta.rank : vic_rank_q;

  assign upd_go = (state_q == ST_UPDATE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (clr_idx_q == SET_W'(MAX_SETS - 1)) state_d = ST_IDLE;
      ST_IDLE:   if (accept) state_d = ST_SCAN;
      ST_SCAN:   if (scan_hit || scan_last) state_d = ST_UPDATE;
      ST_UPDATE: if (upd_go) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_idx_q <= '0;
      cmp_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_idx_q <= clr_idx_q + SET_W'(1);
      end
      if (accept) begin
        cmp_q <= '0;
      end else if (state_q == ST_SCAN && !scan_hit && !scan_last) begin
        cmp_q <= cmp_q + WAY_W'(1);
      end
    end
  end

  // item context, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      set_q        <= set_d;
      tag_q        <= tag_d;
      is_write_q   <= (in_data_i.cmd == CMD_WRITE);
      free_found_q <= 1'b0;
    end else if (state_q == ST_SCAN) begin
      free_found_q <= free_found_s;
      free_way_q   <= free_way_s;
      vic_way_q    <= vic_way_s;
      vic_rank_q   <= vic_rank_s;
      if (scan_hit) begin
        sel_way_q   <= cmp_q;
        hit_q       <= 1'b1;
        fill_free_q <= 1'b0;
      end else if (scan_last) begin
        hit_q       <= 1'b0;
        fill_free_q <= free_found_s;
        sel_way_q   <= free_found_s ? free_way_s : vic_way_s;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Age update for the set, valid and dirty update for the chosen way
  // ---------------------------------------------------------------------------
  line_meta_t [MAX_WAYS-1:0] meta_new;
  logic [RANK_W-1:0]         sel_rank;
  line_meta_t                sel_meta;
  logic                      wb_needed;
  logic [WAY_W+2:0]          way_ext;

  assign sel_meta = meta_rd_q[sel_way_q];
  assign sel_rank = sel_meta.rank;

  always_comb begin
    meta_new = meta_rd_q;
    for (int k = 0; k < MAX_WAYS; k++) begin
      if ((WAY_CNT_W'(k) < ways_eff) && (WAY_W'(k) != sel_way_q) && meta_rd_q[k].valid) begin
        if ((fill_free_q || meta_rd_q[k].rank < sel_rank) &&
            (meta_rd_q[k].rank != RANK_MAX)) begin
          meta_new[k].rank = meta_rd_q[k].rank + RANK_W'(1);
        end
      end
    end
    meta_new[sel_way_q].rank  = '0;
    meta_new[sel_way_q].valid = 1'b1;
    meta_new[sel_way_q].dirty = hit_q ? (sel_meta.dirty || is_write_q) : is_write_q;
  end

  assign wb_needed = !hit_q && !fill_free_q && sel_meta.dirty;
  assign way_ext   = {3'b000, sel_way_q};

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      tag_rd_q <= tag_mem[{set_d, {WAY_W{1'b0}}}];
    end else if (state_q == ST_SCAN && !scan_hit && !scan_last) begin
      tag_rd_q <= tag_mem[{set_q, cmp_q + WAY_W'(1)}];
    end
    if (upd_go && !hit_q) begin
      tag_mem[{set_q, sel_way_q}] <= tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      meta_rd_q <= meta_mem[set_d];
    end
    if (state_q == ST_CLEAR) begin
      meta_mem[clr_idx_q] <= '0;
    end else if (upd_go) begin
      meta_mem[set_q] <= meta_new;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (upd_go) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_go) begin
      out_data_q.hit              <= hit_q;
      out_data_q.writeback_needed <= wb_needed;
      out_data_q.way_used         <= way_ext[2:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `SAWBC_ASSERT_NEXT(a_accept_starts_walk, accept, state_q == ST_SCAN, "accept did not start walk")
  `SAWBC_ASSERT_NOW(a_result_from_update, $rose(out_valid_q), $past(state_q) == ST_UPDATE, "result without update")
  `SAWBC_ASSERT_NOW(a_hit_no_writeback, out_valid_o, !(out_data_o.hit && out_data_o.writeback_needed), "write-back reported on a hit")
  `SAWBC_ASSERT_NOW(a_walk_in_range, state_q == ST_SCAN, WAY_CNT_W'(cmp_q) < ways_eff, "way walk past associativity")

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the set associative write-back cache lookup
// Drives read and write beats, predicts hit, write-back and way with a
// behavioural copy of the tags, valid, dirty and age bits, and compares
// each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top
  import sawbc_pkg::*;
();

  localparam int unsigned WAY_SLOTS = 8;
  localparam int unsigned SET_SLOTS = 64;
  localparam int unsigned LINE_SLOTS = WAY_SLOTS * SET_SLOTS;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  cache_req_t            in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  cache_rsp_t            out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // predicted line state and register settings
  logic [31:0] tag_mem   [LINE_SLOTS];
  bit          valid_mem [LINE_SLOTS];
  bit          dirty_mem [LINE_SLOTS];
  logic [2:0]  age_mem   [LINE_SLOTS];
  int unsigned cfg_index_bits;
  int unsigned cfg_offset_bits;
  int unsigned cfg_ways;

  cache_rsp_t  expected_rsp[$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_on = 1'b0;
  event        hold_go;
  logic [31:0] tag_pool [12];
  logic [31:0] set_pool [3];

  set_assoc_writeback_cache_lookup i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Age searched valid ways newer than w (all if w was free); w is the newest.
  function automatic void promote_way(int unsigned base, int unsigned ways,
                                      int unsigned w, bit was_valid);
    logic [2:0] r;
    r = age_mem[base + w];
    for (int unsigned k = 0; k < ways; k++) begin
      if (k != w && valid_mem[base + k] && (!was_valid || age_mem[base + k] < r)
          && age_mem[base + k] != RANK_MAX) begin
        age_mem[base + k] = age_mem[base + k] + 3'd1;
      end
    end
    age_mem[base + w] = '0;
  endfunction

  function automatic cache_rsp_t predict_lookup(cache_req_t req);
    cache_rsp_t  rsp;
    int unsigned ways;
    int unsigned set_idx;
    int unsigned base;
    int unsigned w;
    logic [31:0] tag;
    bit          found;
    bit          have_free;
    rsp = '0;
    ways = (cfg_ways == 0) ? 1 : ((cfg_ways > WAY_SLOTS) ? WAY_SLOTS : cfg_ways);
    set_idx = ((req.address >> cfg_offset_bits) & ((32'd1 << cfg_index_bits) - 32'd1))
              % SET_SLOTS;
    tag = req.address >> (cfg_offset_bits + cfg_index_bits);
    base = set_idx * WAY_SLOTS;
    found = 1'b0;
    w = 0;
    for (int unsigned k = 0; k < ways && !found; k++) begin
      if (valid_mem[base + k] && tag_mem[base + k] == tag) begin
        w = k;
        found = 1'b1;
      end
    end
    if (found) begin
      rsp.hit = 1'b1;
      promote_way(base, ways, w, 1'b1);
      if (req.cmd == CMD_WRITE) dirty_mem[base + w] = 1'b1;
    end else begin
      have_free = 1'b0;
      for (int unsigned k = 0; k < ways && !have_free; k++) begin
        if (!valid_mem[base + k]) begin
          w = k;
          have_free = 1'b1;
        end
      end
      if (have_free) begin
        promote_way(base, ways, w, 1'b0);
      end else begin
        // oldest way goes, lowest-numbered on a tie
        w = 0;
        for (int unsigned k = 1; k < ways; k++) begin
          if (age_mem[base + k] > age_mem[base + w]) w = k;
        end
        rsp.writeback_needed = dirty_mem[base + w];
        promote_way(base, ways, w, 1'b1);
      end
      valid_mem[base + w] = 1'b1;
      tag_mem[base + w] = tag;
      dirty_mem[base + w] = (req.cmd == CMD_WRITE);
    end
    rsp.way_used = 3'(w);
    return rsp;
  endfunction

  task automatic check_result(input cache_rsp_t got);
    cache_rsp_t want;
    if (expected_rsp.size() == 0) begin
      report_mismatch($sformatf("result beat with nothing expected: %p", got));
      return;
    end
    want = expected_rsp.pop_front();
    if (got.hit !== want.hit)
      report_mismatch($sformatf("hit %0b, expected %0b", got.hit, want.hit));
    if (got.writeback_needed !== want.writeback_needed)
      report_mismatch($sformatf("writeback_needed %0b, expected %0b",
                                got.writeback_needed, want.writeback_needed));
    if (got.way_used !== want.way_used)
      report_mismatch($sformatf("way_used %0d, expected %0d", got.way_used, want.way_used));
  endtask

  // long receiver hold, counted here while the sender keeps going
  initial begin
    forever begin
      @(hold_go);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_on <= 1'b0;
    end
  end

  // result side: check accepted beats, then pick the stall for the next edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_result(out_data);
      if (hold_on) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Call just after a rising edge; returns just after the accepting edge.
  task automatic send_access(input logic cmd, input logic [31:0] address);
    cache_req_t req;
    req.cmd = cmd;
    req.address = address;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_rsp.push_back(predict_lookup(req));
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_INDEX_BITS:  cfg_index_bits = value & 32'h7;
      REG_OFFSET_BITS: cfg_offset_bits = value & 32'hF;
      REG_WAYS:        cfg_ways = value & 32'hF;
      default: ;
    endcase
    // read it back
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got !== value)
      report_mismatch($sformatf("register %0d reads %0h, written %0h", idx, got, value));
  endtask

  task automatic set_layout(input int unsigned ib, input int unsigned ob,
                            input int unsigned ways);
    write_reg(REG_INDEX_BITS, ib);
    write_reg(REG_OFFSET_BITS, ob);
    write_reg(REG_WAYS, ways);
  endtask

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_SENDER:   begin send_idle_pct = 62; recv_stall_pct = 0; end
      IDLE_RECEIVER: begin send_idle_pct = 0; recv_stall_pct = 62; end
      IDLE_BOTH:     begin send_idle_pct = 6; recv_stall_pct = 6; end
      default:       begin send_idle_pct = 0; recv_stall_pct = 0; end
    endcase
  endtask

  // Drop valid, wait for every predicted beat, then let the block settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // Build an address from a few sets and a few tags so that lines get reused.
  function automatic logic [31:0] pick_address();
    int unsigned ways;
    logic [31:0] low_mask;
    logic [31:0] set_mask;
    logic [31:0] tag_part;
    if ($urandom_range(99) < 8) return $urandom();
    ways = (cfg_ways == 0) ? 1 : ((cfg_ways > WAY_SLOTS) ? WAY_SLOTS : cfg_ways);
    low_mask = (32'd1 << (cfg_offset_bits + cfg_index_bits)) - 32'd1;
    set_mask = ((32'd1 << cfg_index_bits) - 32'd1) << cfg_offset_bits;
    tag_part = tag_pool[$urandom_range(ways + 1)];
    return (tag_part & ~low_mask)
         | ((set_pool[$urandom_range(2)] << cfg_offset_bits) & set_mask)
         | ($urandom() & ((32'd1 << cfg_offset_bits) - 32'd1));
  endfunction

  task automatic test_basic_lookup();
    set_idling(IDLE_NONE);
    set_layout(4, 3, 4);
    // fill the four ways of set 0, then hit, dirty, and evict clean and dirty
    send_access(CMD_READ, 32'h0000_0000);
    send_access(CMD_WRITE, 32'h0000_0080);
    send_access(CMD_READ, 32'h0000_0100);
    send_access(CMD_WRITE, 32'h0000_0187);
    send_access(CMD_READ, 32'h0000_0085);
    send_access(CMD_WRITE, 32'h0000_0000);
    send_access(CMD_READ, 32'h0000_0200);
    send_access(CMD_READ, 32'h0000_0280);
    send_access(CMD_READ, 32'h0000_0300);
    send_access(CMD_WRITE, 32'hFFFF_FFFF);
    send_access(CMD_READ, 32'hFFFF_FFFF);
    send_access(CMD_READ, 32'h8000_0078);
    drain_results();
  endtask

  task automatic test_victim_ties();
    set_layout(4, 3, 2);
    send_access(CMD_READ, 32'h0000_0808);
    send_access(CMD_WRITE, 32'h0000_0888);
    drain_results();
    // zero ways acts as one: evict way 0, leaving two ways at the same age
    write_reg(REG_WAYS, 0);
    send_access(CMD_READ, 32'h0000_0908);
    drain_results();
    write_reg(REG_WAYS, 2);
    send_access(CMD_READ, 32'h0000_0988);
    drain_results();
  endtask

  task automatic test_backpressure();
    set_idling(IDLE_NONE);
    set_layout(3, 4, 8);
    foreach (tag_pool[i]) tag_pool[i] = $urandom();
    foreach (set_pool[i]) set_pool[i] = $urandom_range(7);
    // hold the result side off while beats keep coming
    -> hold_go;
    for (int i = 0; i < 40; i++) send_access(1'($urandom_range(1)), pick_address());
    drain_results();
  endtask

  task automatic test_random_traffic();
    int unsigned layouts [11][3] = '{
      '{4, 3, 8}, '{0, 0, 1}, '{6, 12, 8}, '{7, 15, 15}, '{2, 5, 0}, '{3, 2, 3},
      '{5, 4, 6}, '{1, 7, 2}, '{6, 0, 5}, '{0, 12, 8}, '{4, 3, 4}
    };
    for (int p = 0; p < 11; p++) begin
      set_layout(layouts[p][0], layouts[p][1], layouts[p][2]);
      set_idling(idle_mode_e'(p % 4));
      foreach (tag_pool[i]) tag_pool[i] = $urandom();
      foreach (set_pool[i]) set_pool[i] = $urandom_range(127);
      for (int i = 0; i < 118; i++) send_access(1'($urandom_range(1)), pick_address());
      drain_results();
    end
  endtask

  initial begin
    foreach (tag_mem[i]) begin
      tag_mem[i] = '0;
      valid_mem[i] = 1'b0;
      dirty_mem[i] = 1'b0;
      age_mem[i] = '0;
    end
    cfg_index_bits = 4;
    cfg_offset_bits = 3;
    cfg_ways = 8;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_lookup();
    test_victim_ties();
    test_backpressure();
    test_random_traffic();
    set_idling(IDLE_NONE);
    drain_results();
    if (mismatch_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/sawbc_pkg.sv
rtl/set_assoc_writeback_cache_lookup.sv
tb/sv/tb_top.sv
